/* rtl/mse_pkg.sv */
`timescale 1ns / 1ps

package mse_pkg;

  localparam int NUM_STACKS  = 9;
  localparam int STACK_DEPTH = 64;

  // Fixed field widths of the command and result transactions.
  localparam int FieldIdxW = 4;
  localparam int ValW      = 8;
  localparam int NW        = 7;
  localparam int StatW     = 2;
  localparam int CmdW      = 2;

  // Derived internal widths.
  localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int PtrW  = $clog2(STACK_DEPTH);
  localparam int CntW  = $clog2(STACK_DEPTH + 1);
  localparam int CmpW  = ((NW > CntW) ? NW : CntW) + 1;
  localparam int AddrW = $clog2(NUM_STACKS * STACK_DEPTH);

  localparam logic [CmdW-1:0] CmdInsert = 2'd0;
  localparam logic [CmdW-1:0] CmdMove   = 2'd1;
  localparam logic [CmdW-1:0] CmdReport = 2'd2;

  localparam logic [StatW-1:0] StatOk     = 2'd0;
  localparam logic [StatW-1:0] StatTooFew = 2'd1;
  localparam logic [StatW-1:0] StatFull   = 2'd2;
  localparam logic [StatW-1:0] StatBadIdx = 2'd3;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_INSERT,
    DP_LOAD_SRC,
    DP_LOAD_TGT,
    DP_COPY,
    DP_COMMIT,
    DP_REPORT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [SW-1:0]    sel;
    logic [SW-1:0]    src;
    logic [SW-1:0]    tgt;
    logic [NW-1:0]    n;
    logic [ValW-1:0]  val;
    logic             emit;
    logic [StatW-1:0] status;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic sel_full;
    logic too_few;
    logic overflow;
    logic copy_last;
  } dp_stat_t;

endpackage

/* rtl/mse_ctrl.sv */
`timescale 1ns / 1ps

module mse_ctrl import mse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [CmdW-1:0]      command_i,
  input  logic [ValW-1:0]      crate_value_i,
  input  logic [NW-1:0]        move_count_i,
  input  logic [FieldIdxW-1:0] source_stack_i,
  input  logic [FieldIdxW-1:0] target_stack_i,
  output dp_cmd_t              cmd_o,
  input  dp_stat_t             stat_i
);

  localparam int StW = 3;
  localparam logic [StW-1:0] S_IDLE   = 3'd0;
  localparam logic [StW-1:0] S_INS    = 3'd1;
  localparam logic [StW-1:0] S_MV_SRC = 3'd2;
  localparam logic [StW-1:0] S_MV_CHK = 3'd3;
  localparam logic [StW-1:0] S_MV_OVF = 3'd4;
  localparam logic [StW-1:0] S_COPY   = 3'd5;
  localparam logic [StW-1:0] S_COMMIT = 3'd6;
  localparam logic [StW-1:0] S_REP    = 3'd7;

  localparam logic [FieldIdxW:0] NumStacksX = (FieldIdxW+1)'(NUM_STACKS);

  logic [StW-1:0]       state_q, state_d;
  logic [StatW-1:0]     resp_q, resp_d;
  logic                 resp_pend_q, resp_pend_d;
  logic [SW-1:0]        k_q, k_d;
  logic [ValW-1:0]      val_q;
  logic [NW-1:0]        n_q;
  logic [FieldIdxW-1:0] src_q, tgt_q;
  logic                 accept;
  logic                 src_bad, tgt_bad;

  assign busy_o  = (state_q != S_IDLE) || resp_pend_q;
  assign accept  = start_i && !busy_o;
  assign src_bad = {1'b0, source_stack_i} >= NumStacksX;
  assign tgt_bad = {1'b0, target_stack_i} >= NumStacksX;

  always_comb begin
    state_d     = state_q;
    resp_d      = resp_q;
    resp_pend_d = 1'b0;
    k_d         = k_q;
    cmd_o.op     = DP_NOP;
    cmd_o.sel    = '0;
    cmd_o.src    = src_q[SW-1:0];
    cmd_o.tgt    = tgt_q[SW-1:0];
    cmd_o.n      = n_q;
    cmd_o.val    = val_q;
    cmd_o.emit   = 1'b0;
    cmd_o.status = StatOk;
    cmd_o.last   = 1'b1;
    if (resp_pend_q) begin
      // A transaction refused straight at decode answers in the next cycle.
      cmd_o.emit   = 1'b1;
      cmd_o.status = resp_q;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CmdInsert: begin
              if (tgt_bad) begin
                resp_d      = StatBadIdx;
                resp_pend_d = 1'b1;
              end else begin
                state_d = S_INS;
              end
            end
            CmdMove: begin
              if (src_bad || tgt_bad) begin
                resp_d      = StatBadIdx;
                resp_pend_d = 1'b1;
              end else begin
                state_d = S_MV_SRC;
              end
            end
            CmdReport: begin
              k_d     = '0;
              state_d = S_REP;
            end
            default: begin
              resp_d      = StatBadIdx;
              resp_pend_d = 1'b1;
            end
          endcase
        end
      end
      S_INS: begin
        cmd_o.sel  = tgt_q[SW-1:0];
        cmd_o.emit = 1'b1;
        if (stat_i.sel_full) begin
          cmd_o.status = StatFull;
        end else begin
          cmd_o.op = DP_INSERT;
        end
        state_d = S_IDLE;
      end
      S_MV_SRC: begin
        cmd_o.op  = DP_LOAD_SRC;
        cmd_o.sel = src_q[SW-1:0];
        state_d   = S_MV_CHK;
      end
      S_MV_CHK: begin
        cmd_o.op  = DP_LOAD_TGT;
        cmd_o.sel = tgt_q[SW-1:0];
        if (stat_i.too_few) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = StatTooFew;
          state_d      = S_IDLE;
        end else if ((src_q == tgt_q) || (n_q == '0)) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_MV_OVF;
        end
      end
      S_MV_OVF: begin
        if (stat_i.overflow) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = StatFull;
          state_d      = S_IDLE;
        end else begin
          state_d = S_COPY;
        end
      end
      S_COPY: begin
        cmd_o.op = DP_COPY;
        if (stat_i.copy_last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.op   = DP_COMMIT;
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      S_REP: begin
        cmd_o.op   = DP_REPORT;
        cmd_o.sel  = k_q;
        cmd_o.emit = 1'b1;
        cmd_o.last = (k_q == SW'(NUM_STACKS - 1));
        if (cmd_o.last) begin
          state_d = S_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      resp_pend_q <= 1'b0;
      resp_q      <= StatOk;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      resp_pend_q <= resp_pend_d;
      resp_q      <= resp_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q <= crate_value_i;
      n_q   <= move_count_i;
      src_q <= source_stack_i;
      tgt_q <= target_stack_i;
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("final result emitted but the sequencer kept running");

endmodule

/* rtl/mse_datapath.sv */
`timescale 1ns / 1ps

module mse_datapath import mse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 move_mode_we_i,
  input  logic                 move_mode_i,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  output logic                 result_valid_o,
  output logic [StatW-1:0]     status_o,
  output logic [FieldIdxW-1:0] stack_number_o,
  output logic [ValW-1:0]      top_value_o,
  output logic                 stack_empty_o,
  output logic                 last_result_o
);

  logic [ValW-1:0] mem_q [NUM_STACKS*STACK_DEPTH];
  logic [ValW-1:0] rdata_q;

  logic [CntW-1:0] cnt_q [NUM_STACKS];
  logic [PtrW-1:0] bp_q  [NUM_STACKS];

  logic            move_mode_q;
  logic [CntW-1:0] cs_q, ct_q;
  logic [PtrW-1:0] bps_q, bpt_q;
  logic [PtrW-1:0] i_q;
  logic            wr_pend_q;
  logic [AddrW-1:0] wr_addr_q;

  logic             res_valid_q;
  logic [StatW-1:0] res_status_q;
  logic [SW-1:0]    res_num_q;
  logic             res_empty_q, res_rep_q, res_last_q;

  logic [CntW-1:0]  cnt_sel;
  logic [PtrW-1:0]  bp_sel, bp_ins, rep_k;
  logic [CmpW-1:0]  n_x, from_x, to_x;
  logic [AddrW-1:0] raddr, waddr;
  logic             rd_en, wr_en;
  logic [ValW-1:0]  wdata;

  // Store address of height k in stack s, whose ring starts at bp.
  function automatic logic [AddrW-1:0] slot_addr(input logic [SW-1:0] s,
                                                 input logic [PtrW-1:0] bp,
                                                 input logic [PtrW-1:0] k);
    logic [PtrW:0] sum;
    sum = {1'b0, bp} + {1'b0, k};
    if (sum >= (PtrW+1)'(STACK_DEPTH)) begin
      sum = sum - (PtrW+1)'(STACK_DEPTH);
    end
    return AddrW'(s) * AddrW'(STACK_DEPTH) + AddrW'(sum[PtrW-1:0]);
  endfunction

  assign cnt_sel = cnt_q[cmd_i.sel];
  assign bp_sel  = bp_q[cmd_i.sel];
  assign bp_ins  = (bp_sel == '0) ? PtrW'(STACK_DEPTH - 1) : bp_sel - 1'b1;
  assign rep_k   = (cnt_sel == '0) ? '0 : PtrW'(cnt_sel - 1'b1);
  assign n_x     = CmpW'(cmd_i.n);

  // Mode 1 copies the block bottom first; mode 0 pops from the top.
  assign from_x = move_mode_q ? (CmpW'(cs_q) - n_x + CmpW'(i_q))
                              : (CmpW'(cs_q) - CmpW'(1) - CmpW'(i_q));
  assign to_x   = CmpW'(ct_q) + CmpW'(i_q);

  assign stat_o.sel_full  = (cnt_sel >= CntW'(STACK_DEPTH));
  assign stat_o.too_few   = (n_x > CmpW'(cs_q));
  assign stat_o.overflow  = ((CmpW'(ct_q) + n_x) > CmpW'(STACK_DEPTH));
  assign stat_o.copy_last = (CmpW'(i_q) == (n_x - CmpW'(1)));

  always_comb begin
    raddr = '0;
    rd_en = 1'b0;
    case (cmd_i.op)
      DP_COPY: begin
        raddr = slot_addr(cmd_i.src, bps_q, from_x[PtrW-1:0]);
        rd_en = 1'b1;
      end
      DP_REPORT: begin
        raddr = slot_addr(cmd_i.sel, bp_sel, rep_k);
        rd_en = 1'b1;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  assign wr_en = (cmd_i.op == DP_INSERT) || wr_pend_q;
  assign waddr = (cmd_i.op == DP_INSERT) ? slot_addr(cmd_i.sel, bp_ins, '0) : wr_addr_q;
  assign wdata = (cmd_i.op == DP_INSERT) ? cmd_i.val : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STACKS; s++) begin
        cnt_q[s] <= '0;
        bp_q[s]  <= '0;
      end
      move_mode_q <= 1'b0;
      wr_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (move_mode_we_i) begin
        move_mode_q <= move_mode_i;
      end
      if (cmd_i.op == DP_INSERT) begin
        bp_q[cmd_i.sel]  <= bp_ins;
        cnt_q[cmd_i.sel] <= cnt_sel + 1'b1;
      end
      if (cmd_i.op == DP_COMMIT) begin
        cnt_q[cmd_i.tgt] <= CntW'(CmpW'(ct_q) + n_x);
        cnt_q[cmd_i.src] <= CntW'(CmpW'(cs_q) - n_x);
      end
      // The word read in this cycle is written to the target in the next.
      wr_pend_q   <= (cmd_i.op == DP_COPY);
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD_SRC) begin
      cs_q  <= cnt_sel;
      bps_q <= bp_sel;
    end
    if (cmd_i.op == DP_LOAD_TGT) begin
      ct_q  <= cnt_sel;
      bpt_q <= bp_sel;
      i_q   <= '0;
    end else if (cmd_i.op == DP_COPY) begin
      i_q <= i_q + 1'b1;
    end
    if (cmd_i.op == DP_COPY) begin
      wr_addr_q <= slot_addr(cmd_i.tgt, bpt_q, to_x[PtrW-1:0]);
    end
    if (cmd_i.emit) begin
      res_status_q <= cmd_i.status;
      res_last_q   <= cmd_i.last;
      res_rep_q    <= (cmd_i.op == DP_REPORT);
      res_num_q    <= (cmd_i.op == DP_REPORT) ? cmd_i.sel : '0;
      res_empty_q  <= (cmd_i.op == DP_REPORT) && (cnt_sel == '0);
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign stack_number_o = FieldIdxW'(res_num_q);
  assign top_value_o    = (res_rep_q && !res_empty_q) ? rdata_q : '0;
  assign stack_empty_o  = res_empty_q;
  assign last_result_o  = res_last_q;

  a_copy_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_COPY) |-> (cmd_i.src != cmd_i.tgt))
    else $error("copy between a stack and itself");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_INSERT) |-> !stat_o.sel_full)
    else $error("insert into a full stack");

endmodule

/* rtl/multi_stack_move_engine_top.sv */
`timescale 1ns / 1ps

// Channel   Ports                                        Handshake
// command   command_i crate_value_i move_count_i         start && !busy
//           source_stack_i target_stack_i
// result    status_o stack_number_o top_value_o          result_valid_o, one cycle
//           stack_empty_o last_result_o
// config    move_mode_i                                  move_mode_we_i
//
// After acceptance busy covers S_INS on an insert, the pending answer on a refused
// command, S_MV_SRC to S_MV_CHK or S_MV_OVF on a refused or trivial move, all move
// states on a real move, S_REP per stack; each result strobes the cycle after it forms.
// A move copies one item per cycle through the single read and write port of the store.
// Reset empties all stacks at once; the item store itself is not cleared.
// The receiver cannot stall, so results are never held back.
module multi_stack_move_engine_top import mse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [CmdW-1:0]      command_i,
  input  logic [ValW-1:0]      crate_value_i,
  input  logic [NW-1:0]        move_count_i,
  input  logic [FieldIdxW-1:0] source_stack_i,
  input  logic [FieldIdxW-1:0] target_stack_i,
  input  logic                 move_mode_we_i,
  input  logic                 move_mode_i,
  output logic                 result_valid_o,
  output logic [StatW-1:0]     status_o,
  output logic [FieldIdxW-1:0] stack_number_o,
  output logic [ValW-1:0]      top_value_o,
  output logic                 stack_empty_o,
  output logic                 last_result_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mse_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .command_i      (command_i),
    .crate_value_i  (crate_value_i),
    .move_count_i   (move_count_i),
    .source_stack_i (source_stack_i),
    .target_stack_i (target_stack_i),
    .cmd_o          (cmd),
    .stat_i         (stat)
  );

  mse_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .move_mode_we_i (move_mode_we_i),
    .move_mode_i    (move_mode_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .stack_number_o (stack_number_o),
    .top_value_o    (top_value_o),
    .stack_empty_o  (stack_empty_o),
    .last_result_o  (last_result_o)
  );

endmodule
